>>> rtl/core/cnf_pkg.sv
`default_nettype none

package cnf_pkg;

   // Default sizes for the top level
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 17;

   // Filter state format: signed 32 bits, 24 fraction bits
   localparam int STATE_WIDTH = 32;
   localparam int STATE_FRAC  = 24;
   // Accumulator wide enough for eight saturated state terms
   localparam int ACC_WIDTH   = 36;
   localparam int NUM_FILT    = 7;

   // Mode register
   localparam int MODE_WIDTH = 2;
   localparam logic [MODE_WIDTH-1:0] MODE_WHITE = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_BROWN = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_PINK1 = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_PINK2 = 2'd3;

   // Datapath action on the product issued by the previous step
   localparam int ACT_WIDTH = 4;
   localparam logic [ACT_WIDTH-1:0] ACT_NONE    = 4'd0;  // no action
   localparam logic [ACT_WIDTH-1:0] ACT_TLOAD   = 4'd1;  // t = r
   localparam logic [ACT_WIDTH-1:0] ACT_SEC     = 4'd2;  // reg[wr] = sat(t + r), acc += it
   localparam logic [ACT_WIDTH-1:0] ACT_ACC_R   = 4'd3;  // acc += r
   localparam logic [ACT_WIDTH-1:0] ACT_DELAY   = 4'd4;  // acc += reg[rd], reg[wr] = sat(r)
   localparam logic [ACT_WIDTH-1:0] ACT_T_ADD   = 4'd5;  // t = reg[rd] + r
   localparam logic [ACT_WIDTH-1:0] ACT_STORE   = 4'd6;  // reg[wr] = sat(r), acc += it
   localparam logic [ACT_WIDTH-1:0] ACT_OUT     = 4'd7;  // round product to a sample
   localparam logic [ACT_WIDTH-1:0] ACT_WHITE   = 4'd8;  // pass the input sample

   // Multiplier operand A source
   localparam int ASEL_WIDTH = 2;
   localparam logic [ASEL_WIDTH-1:0] ASEL_REG = 2'd0;
   localparam logic [ASEL_WIDTH-1:0] ASEL_W   = 2'd1;
   localparam logic [ASEL_WIDTH-1:0] ASEL_T   = 2'd2;
   localparam logic [ASEL_WIDTH-1:0] ASEL_ACC = 2'd3;

   // Filter register indexes
   localparam int FR_WIDTH = 3;
   localparam logic [FR_WIDTH-1:0] FR0 = 3'd0;
   localparam logic [FR_WIDTH-1:0] FR1 = 3'd1;
   localparam logic [FR_WIDTH-1:0] FR2 = 3'd2;
   localparam logic [FR_WIDTH-1:0] FR3 = 3'd3;
   localparam logic [FR_WIDTH-1:0] FR4 = 3'd4;
   localparam logic [FR_WIDTH-1:0] FR5 = 3'd5;
   localparam logic [FR_WIDTH-1:0] FR6 = 3'd6;

   // Coefficient table codes
   localparam int NUM_COEF = 26;
   localparam int CF_WIDTH = 5;
   localparam logic [CF_WIDTH-1:0] CF_BR_IN    = 5'd0;
   localparam logic [CF_WIDTH-1:0] CF_BR_LEAK  = 5'd1;
   localparam logic [CF_WIDTH-1:0] CF_BR_OUT   = 5'd2;
   localparam logic [CF_WIDTH-1:0] CF_P1_POLE0 = 5'd3;
   localparam logic [CF_WIDTH-1:0] CF_P1_FEED0 = 5'd4;
   localparam logic [CF_WIDTH-1:0] CF_P1_POLE1 = 5'd5;
   localparam logic [CF_WIDTH-1:0] CF_P1_FEED1 = 5'd6;
   localparam logic [CF_WIDTH-1:0] CF_P1_POLE2 = 5'd7;
   localparam logic [CF_WIDTH-1:0] CF_P1_FEED2 = 5'd8;
   localparam logic [CF_WIDTH-1:0] CF_P1_DIR   = 5'd9;
   localparam logic [CF_WIDTH-1:0] CF_P1_OUT   = 5'd10;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE0 = 5'd11;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED0 = 5'd12;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE1 = 5'd13;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED1 = 5'd14;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE2 = 5'd15;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED2 = 5'd16;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE3 = 5'd17;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED3 = 5'd18;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE4 = 5'd19;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED4 = 5'd20;
   localparam logic [CF_WIDTH-1:0] CF_P2_POLE5 = 5'd21;
   localparam logic [CF_WIDTH-1:0] CF_P2_FEED5 = 5'd22;
   localparam logic [CF_WIDTH-1:0] CF_P2_DIR   = 5'd23;
   localparam logic [CF_WIDTH-1:0] CF_P2_DLY   = 5'd24;
   localparam logic [CF_WIDTH-1:0] CF_P2_OUT   = 5'd25;

   // Program counter
   localparam int PC_WIDTH = 6;
   localparam logic [PC_WIDTH-1:0] PC_WHITE = 6'd0;
   localparam logic [PC_WIDTH-1:0] PC_BROWN = 6'd1;
   localparam logic [PC_WIDTH-1:0] PC_PINK1 = 6'd7;
   localparam logic [PC_WIDTH-1:0] PC_PINK2 = 6'd17;

   // One control word
   typedef struct packed {
      logic [ACT_WIDTH-1:0]  act;
      logic [ASEL_WIDTH-1:0] a_sel;
      logic [CF_WIDTH-1:0]   coef;
      logic [FR_WIDTH-1:0]   rd;
      logic [FR_WIDTH-1:0]   wr;
      logic                  last;
   } ucode_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic      start;
      logic      step;
      ucode_type uc;
   } ctl_type;

   // State saturation limits, in accumulator-plus-one width
   localparam logic signed [ACC_WIDTH:0] STATE_HI =
      (ACC_WIDTH+1)'((64'sd1 <<< (STATE_WIDTH-1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH:0] STATE_LO =
      (ACC_WIDTH+1)'(-(64'sd1 <<< (STATE_WIDTH-1)));

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [ACC_WIDTH:0] v);
      logic signed [STATE_WIDTH-1:0] r;
      if (v > STATE_HI) begin
         r = STATE_HI[STATE_WIDTH-1:0];
      end else if (v < STATE_LO) begin
         r = STATE_LO[STATE_WIDTH-1:0];
      end else begin
         r = v[STATE_WIDTH-1:0];
      end
      return r;
   endfunction

   // Program entry per mode
   function automatic logic [PC_WIDTH-1:0] entry_pc(input logic [MODE_WIDTH-1:0] mode);
      logic [PC_WIDTH-1:0] pc;
      unique case (mode)
         MODE_WHITE: pc = PC_WHITE;
         MODE_BROWN: pc = PC_BROWN;
         MODE_PINK1: pc = PC_PINK1;
         MODE_PINK2: pc = PC_PINK2;
         default:    pc = PC_WHITE;
      endcase
      return pc;
   endfunction

   // Microprogram. Each step issues one multiply and acts on the product
   // issued by the step before it.
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type uc;
      unique case (pc)
         // white
         6'd0:  uc = '{ACT_WHITE, ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b1};
         // brown: t = r0 + w*in; r0 = sat(t*leak); out = r0*gain
         6'd1:  uc = '{ACT_NONE,  ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b0};
         6'd2:  uc = '{ACT_T_ADD, ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b0};
         6'd3:  uc = '{ACT_NONE,  ASEL_T,   CF_BR_LEAK,  FR0, FR0, 1'b0};
         6'd4:  uc = '{ACT_STORE, ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b0};
         6'd5:  uc = '{ACT_NONE,  ASEL_ACC, CF_BR_OUT,   FR0, FR0, 1'b0};
         6'd6:  uc = '{ACT_OUT,   ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b1};
         // fast pink: three sections and a direct term
         6'd7:  uc = '{ACT_NONE,  ASEL_REG, CF_P1_POLE0, FR0, FR0, 1'b0};
         6'd8:  uc = '{ACT_TLOAD, ASEL_W,   CF_P1_FEED0, FR0, FR0, 1'b0};
         6'd9:  uc = '{ACT_SEC,   ASEL_REG, CF_P1_POLE1, FR1, FR0, 1'b0};
         6'd10: uc = '{ACT_TLOAD, ASEL_W,   CF_P1_FEED1, FR1, FR1, 1'b0};
         6'd11: uc = '{ACT_SEC,   ASEL_REG, CF_P1_POLE2, FR2, FR1, 1'b0};
         6'd12: uc = '{ACT_TLOAD, ASEL_W,   CF_P1_FEED2, FR2, FR2, 1'b0};
         6'd13: uc = '{ACT_SEC,   ASEL_W,   CF_P1_DIR,   FR2, FR2, 1'b0};
         6'd14: uc = '{ACT_ACC_R, ASEL_W,   CF_P1_DIR,   FR0, FR0, 1'b0};
         6'd15: uc = '{ACT_NONE,  ASEL_ACC, CF_P1_OUT,   FR0, FR0, 1'b0};
         6'd16: uc = '{ACT_OUT,   ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b1};
         // accurate pink: six sections, delayed input and direct term
         6'd17: uc = '{ACT_NONE,  ASEL_REG, CF_P2_POLE0, FR0, FR0, 1'b0};
         6'd18: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED0, FR0, FR0, 1'b0};
         6'd19: uc = '{ACT_SEC,   ASEL_REG, CF_P2_POLE1, FR1, FR0, 1'b0};
         6'd20: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED1, FR1, FR1, 1'b0};
         6'd21: uc = '{ACT_SEC,   ASEL_REG, CF_P2_POLE2, FR2, FR1, 1'b0};
         6'd22: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED2, FR2, FR2, 1'b0};
         6'd23: uc = '{ACT_SEC,   ASEL_REG, CF_P2_POLE3, FR3, FR2, 1'b0};
         6'd24: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED3, FR3, FR3, 1'b0};
         6'd25: uc = '{ACT_SEC,   ASEL_REG, CF_P2_POLE4, FR4, FR3, 1'b0};
         6'd26: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED4, FR4, FR4, 1'b0};
         6'd27: uc = '{ACT_SEC,   ASEL_REG, CF_P2_POLE5, FR5, FR4, 1'b0};
         6'd28: uc = '{ACT_TLOAD, ASEL_W,   CF_P2_FEED5, FR5, FR5, 1'b0};
         6'd29: uc = '{ACT_SEC,   ASEL_W,   CF_P2_DIR,   FR5, FR5, 1'b0};
         6'd30: uc = '{ACT_ACC_R, ASEL_W,   CF_P2_DLY,   FR6, FR6, 1'b0};
         6'd31: uc = '{ACT_DELAY, ASEL_W,   CF_BR_IN,    FR6, FR6, 1'b0};
         6'd32: uc = '{ACT_NONE,  ASEL_ACC, CF_P2_OUT,   FR0, FR0, 1'b0};
         6'd33: uc = '{ACT_OUT,   ASEL_W,   CF_BR_IN,    FR0, FR0, 1'b1};
         default: uc = '{ACT_NONE, ASEL_W,  CF_BR_IN,    FR0, FR0, 1'b1};
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cnf_seq.sv
`default_nettype none

module cnf_seq
   import cnf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [MODE_WIDTH-1:0] mode,
   input  logic                  out_full,
   output ctl_type               ctl,
   output logic                  busy
);

   logic                busy_ff, busy_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   ucode_type           uc;
   logic                step;

   // Control word fetch
   assign uc = ucode_rom(pc_ff);

   // The output step waits while the result register is still full
   assign step = busy_ff & ~(uc.last & out_full);

   assign ctl.start = start;
   assign ctl.step  = step;
   assign ctl.uc    = uc;
   assign busy      = busy_ff;

   // Step counter with dispatch on mode at item start
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = entry_pc(mode);
      end else if (step) begin
         if (uc.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_WHITE;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (step && !uc.last) |=> (busy_ff && pc_ff == $past(pc_ff) + 1'b1))
      else $error("sequencer did not advance");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (step && uc.last) |=> !busy_ff)
      else $error("sequencer did not return to idle");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !step) |=> (busy_ff && $stable(pc_ff)))
      else $error("sequencer moved while held");

   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && pc_ff == entry_pc($past(mode))))
      else $error("wrong program entry");

endmodule

`default_nettype wire

>>> rtl/core/cnf_dp.sv
`default_nettype none

module cnf_dp
   import cnf_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  ctl_type                        ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] req_white_sample,
   input  logic                           req_block_end,
   output logic signed [SAMPLE_WIDTH-1:0] out_sample,
   output logic                           out_clip,
   output logic                           out_last
);

   localparam int CW     = COEF_FRAC_BITS + 3;
   localparam int PW     = ACC_WIDTH + CW;
   localparam int WSHIFT = STATE_FRAC - (SAMPLE_WIDTH - 1);
   localparam int OSH    = STATE_FRAC + COEF_FRAC_BITS - (SAMPLE_WIDTH - 1);
   localparam int YW     = PW + 1 - OSH;
   localparam longint Dec = 64'sd10000000;

   localparam logic signed [PW:0] RndHalf = (PW+1)'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [PW:0] OutHalf = (PW+1)'(64'sd1 <<< (OSH - 1));
   localparam logic signed [YW-1:0] YMax = YW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [YW-1:0] YMin = YW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

   // Coefficients, rounded half away from zero, in code order
   localparam logic signed [CW-1:0] COEF_TAB [NUM_COEF] = '{
      CW'(((64'sd2 <<< COEF_FRAC_BITS) + 64'sd50) / 64'sd100),
      CW'(((64'sd100 <<< COEF_FRAC_BITS) + 64'sd51) / 64'sd102),
      CW'(((64'sd100 <<< COEF_FRAC_BITS) + 64'sd19) / 64'sd38),
      CW'(((64'sd9976500 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd990460 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd9630000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd2965164 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd5700000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd10526913 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd1848000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd10 <<< COEF_FRAC_BITS) + 64'sd52) / 64'sd104),
      CW'(((64'sd9988600 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd555179 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd9933200 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd750759 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd9690000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd1538520 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd8665000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd3104856 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd5500000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd5329522 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(-(((64'sd7616000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec)),
      CW'(-(((64'sd168980 <<< COEF_FRAC_BITS) + Dec / 2) / Dec)),
      CW'(((64'sd5362000 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd1159260 <<< COEF_FRAC_BITS) + Dec / 2) / Dec),
      CW'(((64'sd10 <<< COEF_FRAC_BITS) + 64'sd51) / 64'sd102)
   };

   logic signed [SAMPLE_WIDTH-1:0] samp_ff, samp_in;
   logic                           last_ff, last_in;
   logic signed [STATE_WIDTH-1:0]  filt_ff [NUM_FILT];
   logic signed [STATE_WIDTH-1:0]  filt_in [NUM_FILT];
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [ACC_WIDTH-1:0]    t_ff, t_in;
   logic signed [PW-1:0]           prod_ff, prod_in;

   logic signed [ACC_WIDTH-1:0]    w_val, rd_val, a_op, r_val;
   logic signed [CW-1:0]           coef_op;
   logic signed [PW-1:0]           mult_val;
   logic signed [PW:0]             rnd_sum, y_sum;
   logic signed [ACC_WIDTH:0]      sum_tr;
   logic signed [STATE_WIDTH-1:0]  sec_val, sat_r;
   logic signed [YW-1:0]           y_val;

   // Operand selection
   assign w_val   = ACC_WIDTH'(samp_ff) <<< WSHIFT;
   assign rd_val  = ACC_WIDTH'(filt_ff[ctl.uc.rd]);
   assign coef_op = COEF_TAB[ctl.uc.coef];

   always_comb begin
      unique case (ctl.uc.a_sel)
         ASEL_REG: a_op = rd_val;
         ASEL_W:   a_op = w_val;
         ASEL_T:   a_op = t_ff;
         ASEL_ACC: a_op = acc_ff;
      endcase
   end

   // Shared multiplier, product registered
   assign mult_val = a_op * coef_op;

   // Previous product rounded half up to state format
   assign rnd_sum = (PW+1)'(prod_ff) + RndHalf;
   assign r_val   = ACC_WIDTH'(rnd_sum >>> COEF_FRAC_BITS);
   assign sum_tr  = (ACC_WIDTH+1)'(t_ff) + (ACC_WIDTH+1)'(r_val);
   assign sec_val = sat_state(sum_tr);
   assign sat_r   = sat_state((ACC_WIDTH+1)'(r_val));

   // Step actions
   always_comb begin
      samp_in = samp_ff;
      last_in = last_ff;
      filt_in = filt_ff;
      acc_in  = acc_ff;
      t_in    = t_ff;
      prod_in = prod_ff;
      if (ctl.start) begin
         samp_in = req_white_sample;
         last_in = req_block_end;
         acc_in  = '0;
      end else if (ctl.step) begin
         prod_in = mult_val;
         unique case (ctl.uc.act)
            ACT_TLOAD: t_in = r_val;
            ACT_SEC: begin
               filt_in[ctl.uc.wr] = sec_val;
               acc_in = acc_ff + ACC_WIDTH'(sec_val);
            end
            ACT_ACC_R: acc_in = acc_ff + r_val;
            ACT_DELAY: begin
               filt_in[ctl.uc.wr] = sat_r;
               acc_in = acc_ff + rd_val;
            end
            ACT_T_ADD: t_in = rd_val + r_val;
            ACT_STORE: begin
               filt_in[ctl.uc.wr] = sat_r;
               acc_in = acc_ff + ACC_WIDTH'(sat_r);
            end
            default: ;
         endcase
      end
   end

   // Output rounding and saturation
   assign y_sum = (PW+1)'(prod_ff) + OutHalf;
   assign y_val = YW'(y_sum >>> OSH);

   always_comb begin
      out_clip   = 1'b0;
      out_sample = samp_ff;
      if (ctl.uc.act != ACT_WHITE) begin
         if (y_val > YMax) begin
            out_sample = YMax[SAMPLE_WIDTH-1:0];
            out_clip   = 1'b1;
         end else if (y_val < YMin) begin
            out_sample = YMin[SAMPLE_WIDTH-1:0];
            out_clip   = 1'b1;
         end else begin
            out_sample = y_val[SAMPLE_WIDTH-1:0];
         end
      end
   end

   assign out_last = last_ff;

   // Filter registers clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FILT; i++) begin
            filt_ff[i] <= '0;
         end
      end else begin
         filt_ff <= filt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      samp_ff <= samp_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/colored_noise_filter.sv
`default_nettype none

// Colored noise filter: one white sample in, one colored sample out.
// Request channel (req_): req_valid, req_stall, white sample and block-end
// mark. An item is taken when req_valid is high and req_stall low. Response
// channel (rsp_): rsp_valid, rsp_stall, noise sample, clipped flag and the
// block-end mark of the same item.
// Mode register (csr_): csr_valid/csr_ready write of the 2-bit noise_mode,
// 0 white, 1 brown, 2 fast pink, 3 accurate pink; ready while no item runs.
// A microprogram drives one shared multiplier, one step per cycle; only
// the last step of an item waits while the output register is still full.
// The next item can be taken as soon as the result is written, in the
// cycle in which rsp_valid rises. The microprogram length per mode sets
// how long an item runs.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, a finished item holds at its last step
// until the register frees up.
// Reset (synchronous) clears the seven filter registers, selects white
// mode and empties both channels.
module colored_noise_filter
   import cnf_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_white_sample,
   input  logic                           req_block_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_noise_sample,
   output logic                           rsp_clipped,
   output logic                           rsp_last_in_block,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [MODE_WIDTH-1:0]          csr_noise_mode
);

   logic [MODE_WIDTH-1:0]          mode_ff, mode_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_clip_ff, rsp_clip_in;
   logic                           rsp_last_ff, rsp_last_in;

   ctl_type                        ctl;
   logic                           busy;
   logic                           req_fire;
   logic                           out_full;
   logic                           emit;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;
   logic                           out_clip;
   logic                           out_last;

   assign req_stall = busy;
   assign req_fire  = req_valid & ~busy;
   assign csr_ready = ~busy;
   assign out_full  = rsp_valid_ff & rsp_stall;
   assign emit      = ctl.step & ctl.uc.last;

   cnf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .mode     (mode_ff),
      .out_full (out_full),
      .ctl      (ctl),
      .busy     (busy)
   );

   cnf_dp #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_white_sample (req_white_sample),
      .req_block_end    (req_block_end),
      .out_sample       (out_sample),
      .out_clip         (out_clip),
      .out_last         (out_last)
   );

   // Mode register
   always_comb begin
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_noise_mode;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = out_sample;
         rsp_clip_in   = out_clip;
         rsp_last_in   = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WHITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_noise_sample  = rsp_sample_ff;
   assign rsp_clipped       = rsp_clip_ff;
   assign rsp_last_in_block = rsp_last_ff;

endmodule

`default_nettype wire
